/* rtl/crc32_frame_receiver_macros.svh */
// ----------------------------------------------------------------------------
// CRC-32 frame receiver: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRC32_FRAME_RECEIVER_MACROS_SVH
`define CRC32_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication
`define CFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/crc32fr_pkg.sv */
// ----------------------------------------------------------------------------
// CRC-32 frame receiver package
// Result codes, register indexes, phase encoding and the byte-wide CRC step.
// ----------------------------------------------------------------------------
package crc32fr_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_START_BYTE     = 2'd0,
    REG_MAX_PAYLOAD    = 2'd1,
    REG_BYTE_GAP_LIMIT = 2'd2,
    REG_WINDOW_LIMIT   = 2'd3
  } reg_index_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DROP    = 2'd2,
    KIND_WINDOW  = 2'd3
  } kind_t;

  // Drop reasons
  typedef enum logic [1:0] {
    DROP_GAP    = 2'd0,
    DROP_LENGTH = 2'd1,
    DROP_CRC    = 2'd2,
    DROP_NONE   = 2'd3
  } reason_t;

  // Input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Receive phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CRC     = 4'b1000
  } phase_t;

  // Reset values of the configuration registers
  localparam logic [7:0]  START_BYTE_RST  = 8'd165;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;
  localparam logic [15:0] GAP_LIMIT_RST   = 16'd50;
  localparam logic [31:0] WINDOW_RST      = 32'd3000;

  // CRC constants (zlib, reflected)
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Header byte positions and index of the last trailer byte
  localparam logic [15:0] HDR_LEN_LO = 16'd0;
  localparam logic [15:0] HDR_LEN_HI = 16'd1;
  localparam logic [15:0] HDR_TYPE   = 16'd2;
  localparam logic [15:0] CRC_LAST   = 16'd3;

  // Result queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [1:0]  drop_reason;
    logic        window_bad;
    logic [15:0] dropped_total;
    logic        last;
  } result_t;

  // One byte through the reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/crc32_frame_receiver.sv */
// ----------------------------------------------------------------------------
// CRC-32 frame receiver
// Hunts for a start byte, parses length/type/payload/CRC, passes payload
// bytes on and reports frames accepted, dropped, or receive window expiry.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                      Dir
//  item      item_valid, item_stall, command, rx_byte     in (stall out)
//  result    result_valid, result_stall, kind .. last     out (stall in)
//  config    cfg_we, cfg_index, cfg_data                  in
//
//  Each item is processed combinationally; its results (zero to two) enter
//  a four-entry result queue at the next edge; one result leaves per cycle
//  while result_stall is low. The queue sets the rate: item_stall rises
//  when fewer than two slots are free, so a sustained rate of one item per
//  cycle holds while items give at most one result each and result_stall
//  stays low. rst is synchronous, clears the frame state, empties the queue
//  and returns the configuration registers to their defaults.
module crc32_frame_receiver
  import crc32fr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  frame_type,
  output logic [15:0] frame_length,
  output logic [1:0]  drop_reason,
  output logic        window_bad,
  output logic [15:0] dropped_total,
  output logic        last,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "crc32_frame_receiver_macros.svh"

  // Configuration registers
  logic [7:0]  start_byte;
  logic [15:0] max_payload;
  logic [15:0] byte_gap_limit;
  logic [31:0] window_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= START_BYTE_RST;
      max_payload    <= MAX_PAYLOAD_RST;
      byte_gap_limit <= GAP_LIMIT_RST;
      window_limit   <= WINDOW_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_START_BYTE:     start_byte     <= cfg_data[7:0];
        REG_MAX_PAYLOAD:    max_payload    <= cfg_data[15:0];
        REG_BYTE_GAP_LIMIT: byte_gap_limit <= cfg_data[15:0];
        REG_WINDOW_LIMIT:   window_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state
  phase_t      phase, phase_next;
  logic [15:0] header_length, header_length_next;
  logic [7:0]  header_type, header_type_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] received_crc, received_crc_next;
  logic [15:0] gap_ticks, gap_ticks_next;
  logic [31:0] window_ticks, window_ticks_next;
  logic [15:0] drop_count, drop_count_next;

  // Queue state
  result_t         queue [QDEPTH];
  logic [QAW-1:0]  wr_ptr, rd_ptr;
  logic [QAW:0]    count;

  logic item_accept, result_pop;
  assign item_accept = item_valid && !item_stall;
  assign result_pop  = result_valid && !result_stall;

  // Per-item results
  logic        ev_valid, win_valid;
  kind_t       ev_kind;
  logic [7:0]  ev_data;
  logic [1:0]  ev_reason;
  logic [15:0] ev_drops;
  logic [15:0] drops_mid;
  logic [31:0] crc_upd, rcrc_upd;
  logic [15:0] bs_inc, gap_inc;
  result_t     res0, res1;
  logic [1:0]  res_n;

  assign crc_upd = crc_byte(running_crc, rx_byte);
  assign bs_inc  = bytes_seen + 16'd1;
  assign gap_inc = (gap_ticks != 16'hFFFF) ? gap_ticks + 16'd1 : gap_ticks;
  assign rcrc_upd = received_crc | ({24'd0, rx_byte} << {bytes_seen[1:0], 3'b000});

  // Frame parser and tick handling, one item per cycle while item_stall is low
  always_comb begin
    phase_next         = phase;
    header_length_next = header_length;
    header_type_next   = header_type;
    bytes_seen_next    = bytes_seen;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;
    gap_ticks_next     = gap_ticks;
    window_ticks_next  = window_ticks;
    drops_mid          = drop_count;
    ev_valid           = 1'b0;
    ev_kind            = KIND_PAYLOAD;
    ev_data            = 8'd0;
    ev_reason          = DROP_GAP;
    ev_drops           = drop_count;

    if (command == CMD_BYTE) begin
      if (phase == PH_HUNT) begin
        if (rx_byte == start_byte) begin
          phase_next         = PH_HEADER;
          bytes_seen_next    = 16'd0;
          header_length_next = 16'd0;
          header_type_next   = 8'd0;
          received_crc_next  = 32'd0;
          running_crc_next   = CRC_INIT;
          gap_ticks_next     = 16'd0;
        end
      end else begin
        gap_ticks_next = 16'd0;
        case (phase)
          PH_HEADER: begin
            running_crc_next = crc_upd;
            bytes_seen_next  = bs_inc;
            if (bytes_seen == HDR_LEN_LO) begin
              header_length_next = {8'd0, rx_byte};
            end else if (bytes_seen == HDR_LEN_HI) begin
              header_length_next = header_length | {rx_byte, 8'd0};
            end else begin
              header_type_next = rx_byte;
            end
            if (bytes_seen == HDR_TYPE) begin
              bytes_seen_next = 16'd0;
              if (header_length > max_payload) begin
                // header_length is complete once the type byte arrives
                ev_valid   = 1'b1;
                ev_kind    = KIND_DROP;
                ev_reason  = DROP_LENGTH;
                drops_mid  = (drop_count != 16'hFFFF) ? drop_count + 16'd1 : drop_count;
                ev_drops   = drops_mid;
                phase_next = PH_HUNT;
              end else if (header_length == 16'd0) begin
                phase_next = PH_CRC;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            running_crc_next = crc_upd;
            ev_valid         = 1'b1;
            ev_kind          = KIND_PAYLOAD;
            ev_data          = rx_byte;
            bytes_seen_next  = bs_inc;
            if (bs_inc >= header_length) begin
              bytes_seen_next = 16'd0;
              phase_next      = PH_CRC;
            end
          end
          PH_CRC: begin
            received_crc_next = rcrc_upd;
            bytes_seen_next   = bs_inc;
            if (bytes_seen == CRC_LAST) begin
              bytes_seen_next = 16'd0;
              phase_next      = PH_HUNT;
              ev_valid        = 1'b1;
              if ((running_crc ^ CRC_INIT) == rcrc_upd) begin
                // accepted: result shows the count before the clear
                ev_kind           = KIND_ACCEPT;
                window_ticks_next = 32'd0;
                drops_mid         = 16'd0;
              end else begin
                ev_kind   = KIND_DROP;
                ev_reason = DROP_CRC;
                drops_mid = (drop_count != 16'hFFFF) ? drop_count + 16'd1 : drop_count;
                ev_drops  = drops_mid;
              end
            end
          end
          default: ;
        endcase
      end
    end else begin
      // Tick: window always, byte gap only inside a frame
      if (window_ticks != 32'hFFFF_FFFF) begin
        window_ticks_next = window_ticks + 32'd1;
      end
      if (phase != PH_HUNT) begin
        gap_ticks_next = gap_inc;
        if (gap_inc >= byte_gap_limit) begin
          ev_valid   = 1'b1;
          ev_kind    = KIND_DROP;
          ev_reason  = DROP_GAP;
          drops_mid  = (drop_count != 16'hFFFF) ? drop_count + 16'd1 : drop_count;
          ev_drops   = drops_mid;
          phase_next = PH_HUNT;
        end
      end
    end

    // Window expiry while hunting
    win_valid       = (phase_next == PH_HUNT) && (window_ticks_next >= window_limit);
    drop_count_next = drops_mid;
    if (win_valid) begin
      window_ticks_next = 32'd0;
      drop_count_next   = 16'd0;
    end
  end

  // Assemble up to two results
  always_comb begin
    result_t ev_res, win_res;
    ev_res.kind          = ev_kind;
    ev_res.data_byte     = ev_data;
    ev_res.frame_type    = header_type_next;
    ev_res.frame_length  = header_length_next;
    ev_res.drop_reason   = ev_reason;
    ev_res.window_bad    = 1'b0;
    ev_res.dropped_total = ev_drops;
    ev_res.last          = !win_valid;

    win_res.kind          = KIND_WINDOW;
    win_res.data_byte     = 8'd0;
    win_res.frame_type    = 8'd0;
    win_res.frame_length  = 16'd0;
    win_res.drop_reason   = DROP_GAP;
    win_res.window_bad    = (drops_mid != 16'd0);
    win_res.dropped_total = drops_mid;
    win_res.last          = 1'b1;

    res0  = ev_valid ? ev_res : win_res;
    res1  = win_res;
    res_n = {1'b0, ev_valid} + {1'b0, win_valid};
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      header_length <= 16'd0;
      header_type   <= 8'd0;
      bytes_seen    <= 16'd0;
      running_crc   <= CRC_INIT;
      received_crc  <= 32'd0;
      gap_ticks     <= 16'd0;
      window_ticks  <= 32'd0;
      drop_count    <= 16'd0;
    end else if (item_accept) begin
      phase         <= phase_next;
      header_length <= header_length_next;
      header_type   <= header_type_next;
      bytes_seen    <= bytes_seen_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
      gap_ticks     <= gap_ticks_next;
      window_ticks  <= window_ticks_next;
      drop_count    <= drop_count_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (item_accept && (res_n != 2'd0)) begin
      queue[wr_ptr] <= res0;
      if (res_n == 2'd2) begin
        queue[wr_ptr + QAW'(1)] <= res1;
      end
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (item_accept) begin
        wr_ptr <= wr_ptr + QAW'(res_n);
      end
      if (result_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + (item_accept ? (QAW+1)'(res_n) : '0)
                     - (result_pop ? (QAW+1)'(1) : '0);
    end
  end

  // Stall when a two-result item might not fit
  assign item_stall   = (count > (QAW+1)'(QDEPTH - 2));
  assign result_valid = (count != '0);

  assign kind          = queue[rd_ptr].kind;
  assign data_byte     = queue[rd_ptr].data_byte;
  assign frame_type    = queue[rd_ptr].frame_type;
  assign frame_length  = queue[rd_ptr].frame_length;
  assign drop_reason   = queue[rd_ptr].drop_reason;
  assign window_bad    = queue[rd_ptr].window_bad;
  assign dropped_total = queue[rd_ptr].dropped_total;
  assign last          = queue[rd_ptr].last;

  // Assertions
  `CFR_ASSERT_NOW(a_count_bound, 1'b1, count <= (QAW+1)'(QDEPTH), "result queue overflow")
  `CFR_ASSERT_NEXT(a_count_push, item_accept && !result_pop, count == $past(count) + (QAW+1)'($past(res_n)), "queue count does not track pushed results")
  `CFR_ASSERT_NOW(a_payload_last, result_valid && kind == KIND_PAYLOAD, last, "payload byte not last result of its item")
  `CFR_ASSERT_NOW(a_window_clean, result_valid && kind == KIND_WINDOW, frame_type == 8'd0 && frame_length == 16'd0 && last, "window result carries frame fields")

endmodule
